// ===== hdl/grid_ray_march_dda_unit_assert.svh =====
// assertion macros shared by the ray march unit rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef GRID_RAY_MARCH_DDA_UNIT_ASSERT_SVH
`define GRID_RAY_MARCH_DDA_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GRMD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GRMD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/grmd_pkg.sv =====
// shared types and fixed widths of the ray march unit
// no dependencies; used by the divider and the top level
package grmd_pkg;

	// divider operand widths: gap (19 bits) times magnitude (16 bits), over |dir| (16 bits)
	localparam int NUM_W = 35;
	localparam int DEN_W = 16;

	// width of the running axis distances
	localparam int LEN_W = 37;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== hdl/grid_ray_march_dda_unit.sv =====
// 2d grid ray marcher: wall bitmap in a 1-bit ram, dda walk over linear cell indices
// flow: a write transfer finishes in idle; a cast runs a setup of squares, a square
//   root and up to six divisions, then walks past out-of-range cells without a read
//   and checks each in-range cell with a ram read, then a test
// throughput: one cast in flight; a new item is taken once the cast reaches its result
// reset: arst_n clears control, then a clearing pass zeroes every cell of the map
// depends on grmd_pkg, grmd_ram, grmd_div and grid_ray_march_dda_unit_assert.svh
`include "grid_ray_march_dda_unit_assert.svh"

module grid_ray_march_dda_unit #(
	parameter int MAX_CELLS = 4096,
	parameter int DIST_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [11:0] cell_index,
	input  logic        wall_flag,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] ray_length,
	output logic        hit_wall
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int LW = grmd_pkg::LEN_W;
	localparam logic signed [31:0] MAX_IDX = 32'(MAX_CELLS);
	localparam logic [23:0] DMASK = (DIST_BITS >= 24) ? 24'hFF_FFFF
		: 24'((32'd1 << DIST_BITS) - 32'd1);

	// configuration register indexes
	localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
	localparam logic [1:0] CFG_GRID_CELLS = 2'd1;
	localparam logic [1:0] CFG_CELL_SIZE  = 2'd2;
	localparam logic [1:0] CFG_MAX_LENGTH = 2'd3;

	// request type
	localparam logic REQ_WRITE = 1'b0;

	// division jobs of the setup phase
	localparam logic [2:0] JOB_CX = 3'd0;
	localparam logic [2:0] JOB_CY = 3'd1;
	localparam logic [2:0] JOB_FX = 3'd2;
	localparam logic [2:0] JOB_IX = 3'd3;
	localparam logic [2:0] JOB_FY = 3'd4;
	localparam logic [2:0] JOB_IY = 3'd5;

	typedef enum logic [11:0] {
		S_CLEAR = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_SQ1   = 12'b0000_0000_0100,
		S_SQ2   = 12'b0000_0000_1000,
		S_SQRT  = 12'b0000_0001_0000,
		S_PREP  = 12'b0000_0010_0000,
		S_GO    = 12'b0000_0100_0000,
		S_WAIT  = 12'b0000_1000_0000,
		S_IDX   = 12'b0001_0000_0000,
		S_STEP  = 12'b0010_0000_0000,
		S_CHK   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [12:0] grid_width_q;
	logic [12:0] grid_cells_q;
	logic [10:0] cell_size_q;
	logic [23:0] max_length_q;

	// cast operands
	logic [23:0] px_q, py_q;
	logic [15:0] adx_q, ady_q;
	logic        dx_pos_q, dy_pos_q;
	logic        vx_q, vy_q;

	// magnitude of the direction
	logic [31:0] sq_q, r_q, bit_q;
	logic [15:0] mag_q;
	logic [31:0] sq_trial;
	logic        sq_ge;
	logic [31:0] r_next;

	// setup results
	logic [2:0]  job_q;
	logic [15:0] cx_q, cy_q;
	logic [10:0] remx_q, remy_q;
	logic [18:0] gapx_q, gapy_q;
	logic [LW-1:0] fx_q, fy_q, ix_q, iy_q;
	logic signed [31:0] idx_q;

	// divider hookup
	logic [grmd_pkg::NUM_W-1:0] num_q;
	logic [grmd_pkg::DEN_W-1:0] den_q;
	logic                       div_start;
	grmd_pkg::div_status_t      div_st;
	logic [grmd_pkg::NUM_W-1:0] div_quot;
	logic [grmd_pkg::DEN_W-1:0] div_rem;

	// walk
	logic          take_x;
	logic [LW-1:0] len_new;
	logic signed [31:0] step_x, step_y, idx_new;
	logic          past_max, in_range, rd_en;
	logic [23:0]   len_q;

	// result
	logic [23:0] res_len_q;
	logic        res_hit_q;
	logic        out_valid_q;
	logic [23:0] ray_length_q;
	logic        hit_wall_q;

	// ram
	logic [AW-1:0] clr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_rdata;

	logic        in_accept;
	logic        wr_ok;
	logic [10:0] cs_eff;
	logic [18:0] cq8;
	logic [18:0] mul_a;
	logic        out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign wr_ok     = 17'(cell_index) < 17'(MAX_CELLS);

	// a zero cell size counts as one
	assign cs_eff = (cell_size_q == 11'd0) ? 11'd1 : cell_size_q;
	assign cq8    = {cs_eff, 8'h00};

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 13'd64;
			grid_cells_q <= 13'd4096;
			cell_size_q  <= 11'd16;
			max_length_q <= 24'hFF_FFFF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GRID_WIDTH: grid_width_q <= cfg_data[12:0];
				CFG_GRID_CELLS: grid_cells_q <= cfg_data[12:0];
				CFG_CELL_SIZE:  cell_size_q  <= cfg_data[10:0];
				CFG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// square root step: one result bit per cycle
	assign sq_trial = r_q + bit_q;
	assign sq_ge    = sq_q >= sq_trial;
	assign r_next   = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

	// multiplier operand for the distance jobs
	always_comb begin
		case (job_q)
			JOB_FX:  mul_a = gapx_q;
			JOB_FY:  mul_a = gapy_q;
			default: mul_a = cq8;
		endcase
	end

	// pick the nearer axis boundary; ties step y
	assign take_x  = vx_q && (!vy_q || (fx_q < fy_q));
	assign len_new = take_x ? fx_q : fy_q;
	assign step_x  = dx_pos_q ? 32'sd1 : -32'sd1;
	assign step_y  = dy_pos_q ? $signed({19'b0, grid_width_q}) : -$signed({19'b0, grid_width_q});
	assign idx_new = idx_q + (take_x ? step_x : step_y);
	assign past_max = len_new > LW'(max_length_q);
	// cells outside the grid are passed over
	assign in_range = !idx_new[31] && (idx_new < $signed({19'b0, grid_cells_q}))
		&& (idx_new < MAX_IDX);
	assign rd_en = (state_q == S_STEP) && (vx_q || vy_q) && !past_max && in_range;

	assign div_start = (state_q == S_GO);
	assign out_free  = !out_valid_q || !out_stall;

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			job_q   <= JOB_CX;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// write transfers finish here; casts start the setup
					if (in_accept && req_type != REQ_WRITE) begin
						state_q <= S_SQ1;
					end
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQRT;
				S_SQRT: begin
					if (bit_q[0]) begin
						job_q   <= JOB_CX;
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_GO;
				S_GO:   state_q <= S_WAIT;
				S_WAIT: begin
					if (div_st.done) begin
						case (job_q)
							JOB_CX: begin
								job_q   <= JOB_CY;
								state_q <= S_PREP;
							end
							JOB_CY: state_q <= S_IDX;
							JOB_FX: begin
								job_q   <= JOB_IX;
								state_q <= S_PREP;
							end
							JOB_IX: begin
								job_q   <= JOB_FY;
								state_q <= vy_q ? S_PREP : S_STEP;
							end
							JOB_FY: begin
								job_q   <= JOB_IY;
								state_q <= S_PREP;
							end
							default: state_q <= S_STEP;
						endcase
					end
				end
				S_IDX: begin
					// zero direction components skip their divisions
					if (vx_q) begin
						job_q   <= JOB_FX;
						state_q <= S_PREP;
					end else if (vy_q) begin
						job_q   <= JOB_FY;
						state_q <= S_PREP;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (!(vx_q || vy_q) || past_max) begin
						state_q <= S_DONE;
					end else if (in_range) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= ram_rdata ? S_DONE : S_STEP;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q     <= pos_x;
				py_q     <= pos_y;
				adx_q    <= dir_x[15] ? 16'(~dir_x + 16'sd1) : dir_x;
				ady_q    <= dir_y[15] ? 16'(~dir_y + 16'sd1) : dir_y;
				dx_pos_q <= !dir_x[15] && (dir_x != 16'sd0);
				dy_pos_q <= !dir_y[15] && (dir_y != 16'sd0);
				vx_q     <= dir_x != 16'sd0;
				vy_q     <= dir_y != 16'sd0;
			end
			S_SQ1: sq_q <= {16'b0, adx_q} * {16'b0, ady_q & 16'h0000} + {16'b0, adx_q} * {16'b0, adx_q};
			S_SQ2: begin
				sq_q  <= sq_q + {16'b0, ady_q} * {16'b0, ady_q};
				r_q   <= '0;
				bit_q <= 32'h4000_0000;
			end
			S_SQRT: begin
				if (sq_ge) begin
					sq_q <= sq_q - sq_trial;
				end
				r_q   <= r_next;
				bit_q <= bit_q >> 2;
				mag_q <= r_next[15:0];
			end
			S_PREP: begin
				case (job_q)
					JOB_CX: begin
						num_q <= grmd_pkg::NUM_W'(px_q[23:8]);
						den_q <= grmd_pkg::DEN_W'(cs_eff);
					end
					JOB_CY: begin
						num_q <= grmd_pkg::NUM_W'(py_q[23:8]);
						den_q <= grmd_pkg::DEN_W'(cs_eff);
					end
					default: begin
						num_q <= {16'b0, mul_a} * {19'b0, mag_q};
						den_q <= (job_q == JOB_FX || job_q == JOB_IX) ? adx_q : ady_q;
					end
				endcase
			end
			S_WAIT: begin
				if (div_st.done) begin
					case (job_q)
						JOB_CX: begin
							cx_q   <= div_quot[15:0];
							remx_q <= div_rem[10:0];
						end
						JOB_CY: begin
							cy_q   <= div_quot[15:0];
							remy_q <= div_rem[10:0];
						end
						JOB_FX: fx_q <= LW'(div_quot);
						JOB_IX: ix_q <= LW'(div_quot);
						JOB_FY: fy_q <= LW'(div_quot);
						default: iy_q <= LW'(div_quot);
					endcase
				end
			end
			S_IDX: begin
				idx_q  <= $signed(32'(cy_q) * 32'(grid_width_q) + 32'(cx_q));
				// distance to the next edge along the step direction
				gapx_q <= dx_pos_q ? (cq8 - {remx_q, px_q[7:0]}) : {remx_q, px_q[7:0]};
				gapy_q <= dy_pos_q ? (cq8 - {remy_q, py_q[7:0]}) : {remy_q, py_q[7:0]};
			end
			S_STEP: begin
				if (vx_q || vy_q) begin
					idx_q <= idx_new;
					len_q <= len_new[23:0];
					if (take_x) begin
						fx_q <= fx_q + ix_q;
					end else begin
						fy_q <= fy_q + iy_q;
					end
				end
				if (!(vx_q || vy_q) || past_max) begin
					res_len_q <= max_length_q;
					res_hit_q <= 1'b0;
				end
			end
			S_CHK: begin
				res_len_q <= len_q;
				res_hit_q <= ram_rdata;
			end
			default: ;
		endcase
	end

	// output register parts the walk from the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			ray_length_q <= res_len_q & DMASK;
			hit_wall_q   <= res_hit_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign ray_length = ray_length_q;
	assign hit_wall   = hit_wall_q;

	// wall map write port: clearing pass or a write transfer
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = in_accept && (req_type == REQ_WRITE) && wr_ok;
			ram_waddr = AW'(cell_index);
			ram_wdata = wall_flag;
		end
	end

	grmd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_CELLS)
	) u_wall_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(idx_new[AW-1:0]),
		.rdata(ram_rdata)
	);

	grmd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (den_q),
		.st    (div_st),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	`GRMD_ASSERT_IMPL(a_div_start_free, clk, arst_n, div_start, !div_st.busy, "divider restarted while busy")
	`GRMD_ASSERT_IMPL(a_chk_after_read, clk, arst_n, state_q == S_CHK, $past(rd_en), "cell test without a map read")
	`GRMD_ASSERT_IMPL(a_hit_within_max, clk, arst_n, state_q == S_DONE && res_hit_q, res_len_q <= max_length_q, "hit beyond max length")
	`GRMD_ASSERT_IMPL(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_DONE, "result loaded outside done")

endmodule

// ===== hdl/grmd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module grmd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/grmd_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on grmd_pkg for operand widths and the status struct
module grmd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [grmd_pkg::NUM_W-1:0] num,
	input  logic [grmd_pkg::DEN_W-1:0] den,
	output grmd_pkg::div_status_t      st,
	output logic [grmd_pkg::NUM_W-1:0] quot,
	output logic [grmd_pkg::DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(grmd_pkg::NUM_W + 1);

	logic [grmd_pkg::NUM_W-1:0] num_q;
	logic [grmd_pkg::DEN_W-1:0] den_q;
	logic [grmd_pkg::DEN_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [grmd_pkg::DEN_W:0]   trial;
	logic                       ge;

	assign trial = {rem_q, num_q[grmd_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(grmd_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? grmd_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[grmd_pkg::DEN_W-1:0];
			num_q <= {num_q[grmd_pkg::NUM_W-2:0], ge};
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign quot    = num_q;
	assign rem     = rem_q;

endmodule
